// ===== src/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, constants and codes for the per-flow counter table.
// ----------------------------------------------------------------------------
package fct_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 64;
   localparam int COUNT_BITS    = 32;
   localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int KEY_BITS      = 48;

   // transaction field widths
   localparam int IP_BITS       = 32;
   localparam int PORT_BITS     = 16;
   localparam int STATUS_BITS   = 3;
   localparam int SLOT_BITS     = 6;
   localparam int MSG_BITS      = 32;

   typedef enum logic {
      KIND_DATA  = 1'b0,
      KIND_CLOSE = 1'b1
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_HIT        = 3'd0,
      STAT_NEW        = 3'd1,
      STAT_FULL       = 3'd2,
      STAT_CLOSED     = 3'd3,
      STAT_CLOSE_MISS = 3'd4
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [IP_BITS-1:0]   src_ip;
      logic [PORT_BITS-1:0] src_port;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [SLOT_BITS-1:0] slot;
      logic [MSG_BITS-1:0]  msg_count;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      FSM_IDLE   = 4'b0001,
      FSM_SCAN   = 4'b0010,
      FSM_FINISH = 4'b0100,
      FSM_COMMIT = 4'b1000
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } ctrl_status_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

endpackage

// ===== src/fct_ram.sv =====
// ----------------------------------------------------------------------------
// fct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fct_ctrl.sv =====
// ----------------------------------------------------------------------------
// fct_ctrl
// Controller: sequences load, table scan, final compare and commit.
// ----------------------------------------------------------------------------
module fct_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  fct_pkg::ctrl_status_type stat,
   output fct_pkg::ctrl_cmd_type    cmd
);

   fct_pkg::fsm_type state_ff;
   fct_pkg::fsm_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fct_pkg::FSM_IDLE: begin
            if (start) state_in = fct_pkg::FSM_SCAN;
         end
         fct_pkg::FSM_SCAN: begin
            if (stat.scan_last) state_in = fct_pkg::FSM_FINISH;
         end
         fct_pkg::FSM_FINISH: begin
            state_in = fct_pkg::FSM_COMMIT;
         end
         fct_pkg::FSM_COMMIT: begin
            state_in = fct_pkg::FSM_IDLE;
         end
         default: begin
            state_in = fct_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fct_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   assign busy       = (state_ff != fct_pkg::FSM_IDLE);
   assign cmd.load   = (state_ff == fct_pkg::FSM_IDLE) && start;
   assign cmd.scan   = (state_ff == fct_pkg::FSM_SCAN);
   assign cmd.commit = (state_ff == fct_pkg::FSM_COMMIT);

endmodule

// ===== src/fct_datapath.sv =====
// ----------------------------------------------------------------------------
// fct_datapath
// Table storage, scan compare pipeline, decision and result register.
// ----------------------------------------------------------------------------
module fct_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  fct_pkg::req_type         req_data,
   input  fct_pkg::ctrl_cmd_type    cmd,
   output fct_pkg::ctrl_status_type stat,
   output logic                     rsp_valid,
   output fct_pkg::rsp_type         rsp_data
);

   localparam logic [fct_pkg::IDX_BITS-1:0] LAST_IDX =
      fct_pkg::IDX_BITS'(fct_pkg::TABLE_ENTRIES - 1);

   // request and scan registers
   fct_pkg::req_type                  req_ff;
   logic [fct_pkg::IDX_BITS-1:0]      scan_idx_ff;
   logic                              cmp_en_ff;
   logic [fct_pkg::IDX_BITS-1:0]      cmp_idx_ff;

   // search results
   logic                              hit_found_ff,  hit_found_in;
   logic [fct_pkg::IDX_BITS-1:0]      hit_idx_ff,    hit_idx_in;
   logic [fct_pkg::COUNT_BITS-1:0]    hit_count_ff,  hit_count_in;
   logic                              free_found_ff, free_found_in;
   logic [fct_pkg::IDX_BITS-1:0]      free_idx_ff,   free_idx_in;

   // entry valid bits
   logic [fct_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   fct_pkg::rsp_type                  rsp_ff, rsp_in;

   // memory ports
   logic                              key_wr_en;
   logic                              cnt_wr_en;
   logic [fct_pkg::IDX_BITS-1:0]      wr_addr;
   logic [fct_pkg::COUNT_BITS-1:0]    cnt_wr_data;
   logic [fct_pkg::KEY_BITS-1:0]      key_rd_data;
   logic [fct_pkg::COUNT_BITS-1:0]    cnt_rd_data;
   logic [fct_pkg::KEY_BITS-1:0]      req_key;
   logic                              entry_match;
   logic [fct_pkg::COUNT_BITS-1:0]    next_count;

   assign req_key = {req_ff.src_ip, req_ff.src_port};

   // key and counter stores
   fct_ram #(
      .WIDTH (fct_pkg::KEY_BITS),
      .DEPTH (fct_pkg::TABLE_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_key),
      .rd_addr (scan_idx_ff),
      .rd_data (key_rd_data)
   );

   fct_ram #(
      .WIDTH (fct_pkg::COUNT_BITS),
      .DEPTH (fct_pkg::TABLE_ENTRIES)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (cnt_rd_data)
   );

   assign stat.scan_last = (scan_idx_ff == LAST_IDX);

   // request capture and scan address
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.load) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      cmp_idx_ff <= scan_idx_ff;
   end

   // compare stage, in the cycle after the read address is presented
   assign entry_match = cmp_en_ff && valid_ff[cmp_idx_ff] && (key_rd_data == req_key);

   always_comb begin
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_count_in  = hit_count_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.load) begin
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else begin
         // lowest matching entry wins
         if (entry_match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx_ff;
            hit_count_in = cnt_rd_data;
         end
         // lowest free entry
         if (cmp_en_ff && !valid_ff[cmp_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
      end
   end

   // saturating increment
   assign next_count = (hit_count_ff == fct_pkg::COUNT_MAX) ? hit_count_ff
                                                            : hit_count_ff + 1'b1;

   // outcome of the transaction
   always_comb begin
      valid_in     = valid_ff;
      key_wr_en    = 1'b0;
      cnt_wr_en    = 1'b0;
      wr_addr      = hit_idx_ff;
      cnt_wr_data  = next_count;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.commit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.slot      = '0;
         rsp_in.msg_count = '0;
         if (req_ff.kind == fct_pkg::KIND_CLOSE) begin
            if (hit_found_ff) begin
               valid_in[hit_idx_ff] = 1'b0;
               rsp_in.status        = fct_pkg::STAT_CLOSED;
               rsp_in.slot          = fct_pkg::SLOT_BITS'(hit_idx_ff);
            end else begin
               rsp_in.status = fct_pkg::STAT_CLOSE_MISS;
            end
         end else if (hit_found_ff) begin
            cnt_wr_en        = 1'b1;
            rsp_in.status    = fct_pkg::STAT_HIT;
            rsp_in.slot      = fct_pkg::SLOT_BITS'(hit_idx_ff);
            rsp_in.msg_count = fct_pkg::MSG_BITS'(next_count);
         end else if (free_found_ff) begin
            key_wr_en             = 1'b1;
            cnt_wr_en             = 1'b1;
            wr_addr               = free_idx_ff;
            cnt_wr_data           = fct_pkg::COUNT_BITS'(1);
            valid_in[free_idx_ff] = 1'b1;
            rsp_in.status         = fct_pkg::STAT_NEW;
            rsp_in.slot           = fct_pkg::SLOT_BITS'(free_idx_ff);
            rsp_in.msg_count      = fct_pkg::MSG_BITS'(1);
         end else begin
            rsp_in.status = fct_pkg::STAT_FULL;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         cmp_en_ff     <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         cmp_en_ff     <= cmd.scan;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/flow_table_counter.sv =====
// ----------------------------------------------------------------------------
// flow_table_counter
// Per-flow message counter table keyed by source address and port.
// ----------------------------------------------------------------------------
// the result strobe follows the load, the table scan, the final compare and the commit
// one transaction at a time: a new start is taken only while idle; the scan
//    reads one table entry per cycle through the key and counter memories
// busy falls in the cycle the result is shown, so the next start is taken then
// reset: synchronous; clears all entry valid bits at once, the table is empty
// the receiver cannot stall, each result is shown for exactly one cycle
module flow_table_counter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fct_pkg::req_type req_data,
   output logic             rsp_valid,
   output fct_pkg::rsp_type rsp_data
);

   fct_pkg::ctrl_cmd_type    cmd;
   fct_pkg::ctrl_status_type stat;

   // sequencer
   fct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // table and result datapath
   fct_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/fct_checker.sv =====
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks on transactions of the flow counter table.
// ----------------------------------------------------------------------------
module fct_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input fct_pkg::rsp_type rsp_data
);

   // an accepted transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // one result per transaction, never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a result never overlaps an ongoing transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // drop and close miss carry no slot and no count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == fct_pkg::STAT_FULL ||
                     rsp_data.status == fct_pkg::STAT_CLOSE_MISS))
      |-> (rsp_data.slot == '0 && rsp_data.msg_count == '0))
      else $error("slot or count set on drop or close miss");

   // a newly claimed entry starts counting at one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == fct_pkg::STAT_NEW)
      |-> (rsp_data.msg_count == fct_pkg::MSG_BITS'(1)))
      else $error("new entry count is not one");

endmodule

bind flow_table_counter fct_checker u_fct_checker (.*);
